>>> design/fqm_pkg.sv
// Shared types and constants for the FIFO queue with maximum query.
// Holds field widths, request and status codes, and the controller/datapath structs.
// No dependencies.
package fqm_pkg;

    localparam int DATA_W        = 32;
    localparam int OP_W          = 2;
    localparam int ST_W          = 2;
    localparam int OCC_W         = 5;
    localparam int DEPTH_DEFAULT = 16;
    localparam int M_TDATA_W     = ((DATA_W + OCC_W + 7) / 8) * 8;

    localparam logic [OP_W-1:0] OP_ENQ = 2'd0;
    localparam logic [OP_W-1:0] OP_DEQ = 2'd1;
    localparam logic [OP_W-1:0] OP_MAX = 2'd2;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic capture;
        logic enq;
        logic deq;
        logic scan_init;
        logic scan_run;
        logic res_ok;
        logic res_empty;
        logic res_full;
        logic res_deq;
        logic res_max;
        logic out_load;
    } fqm_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            empty;
        logic            full;
        logic            scan_done;
        logic            out_free;
    } fqm_sts_t;

endpackage

>>> design/fqm_dpath.sv
// Datapath of the FIFO queue: ring memory, head/tail pointers, entry count,
// maximum scan pipeline, result register and output register.
// Depends on fqm_pkg.
module fqm_dpath #(
    parameter int DEPTH = fqm_pkg::DEPTH_DEFAULT
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [fqm_pkg::DATA_W-1:0] din,
    input  logic [fqm_pkg::OP_W-1:0]   op_in,
    input  fqm_pkg::fqm_cmd_t          cmd,
    output fqm_pkg::fqm_sts_t          sts,
    input  logic                       out_ready,
    output logic                       out_valid,
    output logic [fqm_pkg::DATA_W-1:0] out_data,
    output logic [fqm_pkg::ST_W-1:0]   out_status,
    output logic [fqm_pkg::OCC_W-1:0]  out_occ
);
    import fqm_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    logic [DATA_W-1:0] ring_mem [DEPTH];

    logic [OP_W-1:0]   op_reg;
    logic [DATA_W-1:0] din_reg;
    logic [AW-1:0]     head_reg, head_next;
    logic [AW-1:0]     tail_reg, tail_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [AW-1:0]     scan_idx_reg, scan_idx_next;
    logic [CW-1:0]     left_reg, left_next;
    logic              rd_valid_reg, rd_valid_next;
    logic              first_reg, first_next;
    logic [DATA_W-1:0] best_reg, best_next;
    logic [DATA_W-1:0] rd_data_reg;
    logic [DATA_W-1:0] res_data_reg, res_data_next;
    logic [ST_W-1:0]   res_status_reg, res_status_next;
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_data_reg;
    logic [ST_W-1:0]   out_status_reg;
    logic [OCC_W-1:0]  out_occ_reg;

    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              scan_issue;

    function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] p);
        next_slot = (p == LAST_SLOT) ? '0 : p + 1'b1;
    endfunction

    assign scan_issue = cmd.scan_run && (left_reg != '0);
    assign rd_en      = cmd.deq || scan_issue;
    assign rd_addr    = cmd.deq ? head_reg : scan_idx_reg;

    always_comb begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        scan_idx_next   = scan_idx_reg;
        left_next       = left_reg;
        rd_valid_next   = 1'b0;
        first_next      = first_reg;
        best_next       = best_reg;
        res_data_next   = res_data_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;

        if (cmd.enq) begin
            tail_next  = next_slot(tail_reg);
            count_next = count_reg + 1'b1;
        end
        if (cmd.deq) begin
            head_next  = next_slot(head_reg);
            count_next = count_reg - 1'b1;
        end
        if (cmd.scan_init) begin
            scan_idx_next = head_reg;
            left_next     = count_reg;
            first_next    = 1'b1;
        end
        if (scan_issue) begin
            scan_idx_next = next_slot(scan_idx_reg);
            left_next     = left_reg - 1'b1;
            rd_valid_next = 1'b1;
        end
        if (cmd.scan_run && rd_valid_reg) begin
            first_next = 1'b0;
            if (first_reg || ($signed(rd_data_reg) > $signed(best_reg))) begin
                best_next = rd_data_reg;
            end
        end
        if (cmd.res_ok) begin
            res_data_next   = '0;
            res_status_next = ST_OK;
        end
        if (cmd.res_empty) begin
            res_data_next   = '0;
            res_status_next = ST_EMPTY;
        end
        if (cmd.res_full) begin
            res_data_next   = '0;
            res_status_next = ST_FULL;
        end
        if (cmd.res_deq) begin
            res_data_next   = rd_data_reg;
            res_status_next = ST_OK;
        end
        if (cmd.res_max) begin
            res_data_next   = best_reg;
            res_status_next = ST_OK;
        end
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            left_reg      <= '0;
            rd_valid_reg  <= 1'b0;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            left_reg      <= left_next;
            rd_valid_reg  <= rd_valid_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_idx_reg   <= scan_idx_next;
        best_reg       <= best_next;
        res_data_reg   <= res_data_next;
        res_status_reg <= res_status_next;
        if (cmd.capture) begin
            op_reg  <= op_in;
            din_reg <= din;
        end
        if (cmd.out_load) begin
            out_data_reg   <= res_data_reg;
            out_status_reg <= res_status_reg;
            out_occ_reg    <= OCC_W'(count_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.enq) begin
            ring_mem[tail_reg] <= din_reg;
        end
        if (rd_en) begin
            rd_data_reg <= ring_mem[rd_addr];
        end
    end

    assign sts.op        = op_reg;
    assign sts.empty     = (count_reg == '0);
    assign sts.full      = (count_reg == FULL_CNT);
    assign sts.scan_done = (left_reg == '0) && !rd_valid_reg;
    assign sts.out_free  = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;
    assign out_status = out_status_reg;
    assign out_occ    = out_occ_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_CNT)
        else $error("entry count exceeds the queue depth");

    a_enq_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.enq |-> (count_reg != FULL_CNT))
        else $error("write issued to a full queue");

    a_deq_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.deq |-> (count_reg != '0))
        else $error("read issued to an empty queue");

    a_scan_left_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan_run |-> (left_reg <= count_reg))
        else $error("scan covers more entries than the queue holds");

    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> out_valid_reg)
        else $error("loaded result is not presented");

endmodule

>>> design/fqm_ctrl.sv
// Controller state machine of the FIFO queue with maximum query.
// Decodes the captured request and sequences the datapath through commands.
// Depends on fqm_pkg.
module fqm_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  fqm_pkg::fqm_sts_t sts,
    output fqm_pkg::fqm_cmd_t cmd
);
    import fqm_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_EXEC     = 3'd1;
    localparam logic [2:0] S_DEQ_WAIT = 3'd2;
    localparam logic [2:0] S_SCAN     = 3'd3;
    localparam logic [2:0] S_DONE     = 3'd4;

    logic [2:0] state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_DONE;
                case (sts.op)
                    OP_ENQ: begin
                        if (sts.full) begin
                            cmd.res_full = 1'b1;
                        end else begin
                            cmd.enq    = 1'b1;
                            cmd.res_ok = 1'b1;
                        end
                    end
                    OP_DEQ: begin
                        if (sts.empty) begin
                            cmd.res_empty = 1'b1;
                        end else begin
                            cmd.deq    = 1'b1;
                            state_next = S_DEQ_WAIT;
                        end
                    end
                    OP_MAX: begin
                        if (sts.empty) begin
                            cmd.res_empty = 1'b1;
                        end else begin
                            cmd.scan_init = 1'b1;
                            state_next    = S_SCAN;
                        end
                    end
                    default: begin
                        cmd.res_ok = 1'b1;
                    end
                endcase
            end
            S_DEQ_WAIT: begin
                cmd.res_deq = 1'b1;
                state_next  = S_DONE;
            end
            S_SCAN: begin
                cmd.scan_run = 1'b1;
                if (sts.scan_done) begin
                    cmd.res_max = 1'b1;
                    state_next  = S_DONE;
                end
            end
            S_DONE: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_capture_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |=> (state_reg == S_EXEC))
        else $error("accepted item did not start execution");

    a_load_returns_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> in_ready)
        else $error("controller not ready after delivering a result");

    a_scan_from_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan_init |=> cmd.scan_run)
        else $error("maximum scan did not start after setup");

endmodule

>>> design/fifo_queue_with_max_scan.sv
// Bounded FIFO queue of signed 32-bit values with a maximum query over held entries.
// An enqueue, an unused opcode, or a request refused as empty or full passes from
// acceptance through execution to the result; a dequeue adds a wait state for the
// registered ring-memory read. A maximum query scans the held entries, reading one
// ring-memory entry per cycle through the single read port. One item is worked on at
// a time, while the previous result may still wait in the output register. Dequeue
// or query on an empty queue returns status empty and data 0; enqueue on a full queue
// is dropped with status full.
// Top level; depends on fqm_pkg, fqm_ctrl and fqm_dpath.
module fifo_queue_with_max_scan #(
    parameter int DEPTH = fqm_pkg::DEPTH_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [fqm_pkg::DATA_W-1:0]    s_tdata,  // data_in
    input  logic [fqm_pkg::OP_W-1:0]      s_tuser,  // opcode
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [fqm_pkg::M_TDATA_W-1:0] m_tdata,  // data_out, occupancy, zero pad
    output logic [fqm_pkg::ST_W-1:0]      m_tuser   // status
);
    import fqm_pkg::*;

    fqm_cmd_t          cmd;
    fqm_sts_t          sts;
    logic [DATA_W-1:0] out_data;
    logic [OCC_W-1:0]  out_occ;

    fqm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    fqm_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .din        (s_tdata),
        .op_in      (s_tuser),
        .cmd        (cmd),
        .sts        (sts),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_data   (out_data),
        .out_status (m_tuser),
        .out_occ    (out_occ)
    );

    assign m_tdata = {{(M_TDATA_W - DATA_W - OCC_W){1'b0}}, out_occ, out_data};

endmodule

>>> verif/tb_fifo_queue_with_max_scan.sv
// Self-checking testbench for the FIFO queue with maximum query.
// Directed rows and random traffic are checked against table values or a ring-buffer predictor.
// Depends on fqm_pkg and fifo_queue_with_max_scan.
module tb_fifo_queue_with_max_scan;
    timeunit 1ns;
    timeprecision 1ps;

    import fqm_pkg::*;

    localparam int DEPTH           = DEPTH_DEFAULT;
    localparam int PTR_W           = $clog2(DEPTH);
    localparam int RANDOM_ITEMS    = 2000;
    localparam int IDLE_LIMIT      = 4000;
    localparam int DRAIN_CYCLES    = 40;
    localparam int PRESSURE_AT     = 200;
    localparam int PRESSURE_CYCLES = 400;

    localparam logic [OP_W-1:0] OP_NONE = 2'd3;

    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN, MIX_SCAN} traffic_mix_t;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [ST_W-1:0]   status;
        logic [OCC_W-1:0]  occ;
    } queue_result_t;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] data;
        bit                typed;
        queue_result_t     want;
    } request_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [DATA_W-1:0]    s_tdata;
    logic [OP_W-1:0]      s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [ST_W-1:0]      m_tuser;

    logic signed [DATA_W-1:0] q_mem [DEPTH];
    logic [PTR_W-1:0]         q_head;
    logic [PTR_W-1:0]         q_tail;
    logic [OCC_W-1:0]         q_count;

    queue_result_t expected_results[$];
    request_row_t  directed_rows[$];
    int            error_count;
    int            results_seen;
    int            idle_cycles;

    fifo_queue_with_max_scan #(
        .DEPTH(DEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    task automatic predict_request(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] din,
                                   output queue_result_t r);
        logic signed [DATA_W-1:0] best;
        logic [PTR_W-1:0]         idx;
        r        = '0;
        r.status = ST_OK;
        case (op)
            OP_ENQ: begin
                if (q_count == DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    q_mem[q_tail] = din;
                    q_tail        = q_tail + 1'b1;
                    q_count       = q_count + 1'b1;
                end
            end
            OP_DEQ: begin
                if (q_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.value = q_mem[q_head];
                    q_head  = q_head + 1'b1;
                    q_count = q_count - 1'b1;
                end
            end
            OP_MAX: begin
                if (q_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    idx  = q_head;
                    best = q_mem[idx];
                    for (int n = 0; n < q_count; n++) begin
                        if (q_mem[idx] > best) best = q_mem[idx];
                        idx = idx + 1'b1;
                    end
                    r.value = best;
                end
            end
            default: begin
            end
        endcase
        r.occ = q_count;
    endtask

    function automatic int draw_gap(input bit burst);
        return burst ? 0 : $urandom_range(0, 11);
    endfunction

    task automatic report_mismatch(input string field, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        $display("mismatch at result %0d: %s got %h expected %h", results_seen, field, got, want);
        error_count++;
    endtask

    task automatic add_row(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] data,
                           input bit typed, input logic [DATA_W-1:0] value,
                           input logic [ST_W-1:0] status, input logic [OCC_W-1:0] occ);
        request_row_t row;
        row.op          = op;
        row.data        = data;
        row.typed       = typed;
        row.want.value  = value;
        row.want.status = status;
        row.want.occ    = occ;
        directed_rows.push_back(row);
    endtask

    task automatic send_request(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] din,
                                input int gap, input bit typed, input queue_result_t want);
        queue_result_t predicted;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= din;
        do @(posedge aclk); while (!s_tready);
        predict_request(op, din, predicted);
        expected_results.push_back(typed ? want : predicted);
    endtask

    function automatic logic [OP_W-1:0] pick_op(input traffic_mix_t mix);
        int roll;
        int enq_pct;
        int deq_pct;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:  begin enq_pct = 65; deq_pct = 15; end
            MIX_DRAIN: begin enq_pct = 15; deq_pct = 65; end
            MIX_SCAN:  begin enq_pct = 30; deq_pct = 20; end
            default:   begin enq_pct = 40; deq_pct = 40; end
        endcase
        if (roll < 3) return OP_NONE;
        if (roll < 3 + enq_pct) return OP_ENQ;
        if (roll < 3 + enq_pct + deq_pct) return OP_DEQ;
        return OP_MAX;
    endfunction

    function automatic logic [DATA_W-1:0] pick_data();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
            case ($urandom_range(0, 3))
                0:       return 32'h8000_0000;
                1:       return 32'h7fff_ffff;
                2:       return 32'h0000_0000;
                default: return 32'hffff_ffff;
            endcase
        end
        if (roll < 30) return $urandom_range(0, 15) - 8;
        return $urandom;
    endfunction

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        int            stall;
        int            burst_left;
        bit            burst;
        queue_result_t want;
        logic [M_TDATA_W-1:0] got;
        m_tready   <= 1'b0;
        burst_left = 0;
        burst      = 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(10, 80);
                burst      = ($urandom_range(0, 3) == 0);
            end
            burst_left--;
            stall = (results_seen == PRESSURE_AT) ? PRESSURE_CYCLES : draw_gap(burst);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            got = m_tdata;
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected item, data", got[DATA_W-1:0], '0);
            end else begin
                want = expected_results.pop_front();
                if (got[DATA_W-1:0] !== want.value)
                    report_mismatch("data_out", got[DATA_W-1:0], want.value);
                if (m_tuser !== want.status)
                    report_mismatch("status", DATA_W'(m_tuser), DATA_W'(want.status));
                if (got[DATA_W+OCC_W-1:DATA_W] !== want.occ)
                    report_mismatch("occupancy", DATA_W'(got[DATA_W+OCC_W-1:DATA_W]),
                                    DATA_W'(want.occ));
                if (got[M_TDATA_W-1:DATA_W+OCC_W] !== '0)
                    report_mismatch("padding", DATA_W'(got[M_TDATA_W-1:DATA_W+OCC_W]), '0);
            end
            results_seen++;
        end
    end

    initial begin
        traffic_mix_t  mix;
        int            segment_left;
        bit            burst;
        queue_result_t unused;
        aresetn      <= 1'b0;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        s_tuser      <= OP_ENQ;
        q_head       = '0;
        q_tail       = '0;
        q_count      = '0;
        unused       = '0;

        add_row(OP_DEQ,  32'h1234_5678, 1, 32'h0, ST_EMPTY, 5'd0);
        add_row(OP_MAX,  32'h0,         1, 32'h0, ST_EMPTY, 5'd0);
        add_row(OP_NONE, 32'hffff_ffff, 1, 32'h0, ST_OK,    5'd0);
        add_row(OP_ENQ,  32'h8000_0000, 1, 32'h0, ST_OK,    5'd1);
        add_row(OP_MAX,  32'h0,         1, 32'h8000_0000, ST_OK, 5'd1);
        add_row(OP_ENQ,  32'h7fff_ffff, 1, 32'h0, ST_OK,    5'd2);
        add_row(OP_MAX,  32'h0,         1, 32'h7fff_ffff, ST_OK, 5'd2);
        add_row(OP_DEQ,  32'h0,         1, 32'h8000_0000, ST_OK, 5'd1);
        add_row(OP_ENQ,  32'hffff_ffff, 1, 32'h0, ST_OK,    5'd2);
        add_row(OP_ENQ,  32'h0000_0000, 0, '0, ST_OK, '0);
        add_row(OP_ENQ,  32'h0000_0001, 0, '0, ST_OK, '0);
        add_row(OP_ENQ,  32'hffff_fffe, 0, '0, ST_OK, '0);
        add_row(OP_ENQ,  32'h5555_5555, 0, '0, ST_OK, '0);
        add_row(OP_ENQ,  32'haaaa_aaaa, 0, '0, ST_OK, '0);
        for (int i = 0; i < 9; i++)
            add_row(OP_ENQ, $urandom, 0, '0, ST_OK, '0);
        add_row(OP_ENQ,  32'h7fff_fffe, 1, 32'h0, ST_FULL, 5'd16);
        add_row(OP_MAX,  32'h0,         0, '0, ST_OK, '0);
        add_row(OP_NONE, 32'h0,         1, 32'h0, ST_OK,   5'd16);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            send_request(directed_rows[i].op, directed_rows[i].data, draw_gap(i < 12),
                         directed_rows[i].typed, directed_rows[i].want);

        segment_left = 0;
        mix          = MIX_EVEN;
        burst        = 1'b0;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (segment_left == 0) begin
                segment_left = $urandom_range(20, 120);
                mix          = traffic_mix_t'($urandom_range(0, 3));
                burst        = ($urandom_range(0, 3) == 0);
            end
            segment_left--;
            send_request(pick_op(mix), pick_data(), draw_gap(burst), 0, unused);
        end
        s_tvalid <= 1'b0;

        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> files.f
design/fqm_pkg.sv
design/fqm_dpath.sv
design/fqm_ctrl.sv
design/fifo_queue_with_max_scan.sv
verif/tb_fifo_queue_with_max_scan.sv
